### src/tbmma_pkg.sv
package tbmma_pkg;

	localparam int MAX_COLUMNS = 256;
	localparam int COL_W = $clog2(MAX_COLUMNS);
	localparam int CNT_W = $clog2(MAX_COLUMNS + 1);

	localparam int VAL_W = 24;
	localparam int TIME_W = 32;
	localparam int SUM_W = 64;
	localparam int WGT_W = 48;
	localparam int CTR_W = 40;

	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 48;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_FROM  = 2'd0,
		REG_TO    = 2'd1,
		REG_COLS  = 2'd2,
		REG_SPARE = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_MUL,
		ST_ADD_DGO,
		ST_ADD_DWAIT,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_RD_RD,
		ST_RD_DAT,
		ST_RD_AWAIT,
		ST_RD_CMUL,
		ST_RD_CGO,
		ST_RD_CWAIT,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [VAL_W-1:0] low;
		logic [VAL_W-1:0] high;
		logic [SUM_W-1:0] sum;
		logic [WGT_W-1:0] weight;
	} bin_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

endpackage

### src/tbmma_div.sv
module tbmma_div
	import tbmma_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  div_req_t             req,
	output logic                 done,
	output logic [DIV_NUM_W-1:0] quot
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NUM_W-1:0] n_q;
	logic [DIV_DEN_W-1:0] d_q;
	logic [DIV_DEN_W-1:0] r_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 ge;

	assign trial = {r_q, n_q[DIV_NUM_W-1]};
	assign diff = trial - {1'b0, d_q};
	assign ge = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(DIV_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q <= req.num;
			d_q <= req.den;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			n_q <= {n_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = n_q;

endmodule

### src/tbmma_bin_ram.sv
module tbmma_bin_ram
	import tbmma_pkg::*;
(
	input  logic             clk,
	input  logic             we,
	input  logic [COL_W-1:0] waddr,
	input  bin_t             wdata,
	input  logic             re,
	input  logic [COL_W-1:0] raddr,
	output bin_t             rdata
);

	bin_t mem [MAX_COLUMNS];
	bin_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/time_binned_min_max_average.sv
// Channel  | Direction | Signals                      | Contents
// -------- | --------- | ---------------------------- | ------------------------------------
// s        | in        | s_tvalid s_tready s_tdata    | sample or command transaction
//          |           | s_tuser                      | command
// m        | out       | m_tvalid m_tready m_tdata    | one result per input transaction
// cfg      | in        | cfg_we cfg_index cfg_data    | window start, end, column count
//
// One transaction is processed at a time. An add makes one pass of the shared 64-step
// restoring divider and a read one or two. Clear, unused commands and dropped
// transactions go from idle straight to the finish state. The columns sit in one RAM
// with a registered read port; their valid bits are flops cleared by reset and by a
// clear command.
// A finished result is held in the output register while m_tready is low.
module time_binned_min_max_average
	import tbmma_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// sample_time, duration_q8, value_q8, low_q8, high_q8, column
	input  logic [135:0]  s_tdata,
	// command
	input  logic [1:0]    s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	// accepted, column_has, column_low, column_high, column_avg, center_time_q8, zero pad
	output logic [119:0]  m_tdata,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_data
);

	state_t state_q, state_d;

	logic [TIME_W-1:0] from_q, to_q;
	logic [CNT_W-1:0]  cols_q;
	logic [CNT_W-1:0]  cols_eff;
	logic [TIME_W-1:0] span;
	logic              win_open;

	logic [TIME_W-1:0] t_q;
	logic [VAL_W-1:0]  dur_q, val_q, lo_q, hi_q;
	logic [COL_W-1:0]  col_q;
	logic [COL_W-1:0]  idx_q;
	logic [TIME_W+CNT_W-1:0] mprod_q;
	logic [2*VAL_W-1:0] wprod_q;

	logic              res_acc_q, res_has_q;
	logic [VAL_W-1:0]  res_low_q, res_high_q, res_avg_q;
	logic [CTR_W-1:0]  res_ctr_q;
	logic              m_tvalid_q;
	logic [119:0]      m_tdata_q;

	logic [MAX_COLUMNS-1:0] valid_q;

	div_req_t             div_req;
	logic                 div_done;
	logic [DIV_NUM_W-1:0] quot;

	logic       mem_we, mem_re;
	logic [COL_W-1:0] mem_raddr;
	bin_t       rdata, wdata;
	logic       out_load;
	cmd_t       cmd_in;

	logic [VAL_W-1:0]   w;
	logic [SUM_W:0]     sum_add;
	logic [WGT_W:0]     wgt_add;
	logic               old_valid;
	logic [SUM_W-1:0]   sum_old;
	logic [WGT_W-1:0]   wgt_old;

	assign cmd_in = cmd_t'(s_tuser);
	assign cols_eff = (cols_q > CNT_W'(MAX_COLUMNS)) ? CNT_W'(MAX_COLUMNS) : cols_q;
	assign win_open = (cols_eff != '0) && (to_q > from_q);
	assign span = to_q - from_q;

	assign w = (dur_q == '0) ? VAL_W'(256) : dur_q;
	assign old_valid = valid_q[idx_q];
	assign sum_old = old_valid ? rdata.sum : '0;
	assign wgt_old = old_valid ? rdata.weight : '0;
	assign sum_add = {1'b0, sum_old} + (SUM_W+1)'(wprod_q);
	assign wgt_add = {1'b0, wgt_old} + (WGT_W+1)'(w);

	always_comb begin
		wdata.low = (old_valid && rdata.low <= lo_q) ? rdata.low : lo_q;
		wdata.high = (old_valid && rdata.high >= hi_q) ? rdata.high : hi_q;
		wdata.sum = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
		wdata.weight = wgt_add[WGT_W] ? '1 : wgt_add[WGT_W-1:0];
	end

	tbmma_bin_ram u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (idx_q),
		.wdata (wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	tbmma_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_raddr = col_q;
		div_req.start = 1'b0;
		div_req.num = DIV_NUM_W'(mprod_q);
		div_req.den = DIV_DEN_W'(span);
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_FIN;
					unique case (cmd_in)
						CMD_ADD: begin
							if (win_open && s_tdata[31:0] >= from_q) begin
								state_d = ST_ADD_MUL;
							end
						end
						CMD_READ: begin
							if (win_open && {1'b0, s_tdata[135:128]} < cols_eff) begin
								state_d = ST_RD_RD;
							end
						end
						default: state_d = ST_FIN;
					endcase
				end
			end
			ST_ADD_MUL: state_d = ST_ADD_DGO;
			ST_ADD_DGO: begin
				div_req.start = 1'b1;
				state_d = ST_ADD_DWAIT;
			end
			ST_ADD_DWAIT: begin
				if (div_done) begin
					state_d = ST_ADD_RD;
				end
			end
			ST_ADD_RD: begin
				mem_re = 1'b1;
				mem_raddr = idx_q;
				state_d = ST_ADD_WR;
			end
			ST_ADD_WR: begin
				mem_we = 1'b1;
				state_d = ST_FIN;
			end
			ST_RD_RD: begin
				mem_re = 1'b1;
				state_d = ST_RD_DAT;
			end
			ST_RD_DAT: begin
				if (valid_q[col_q] && rdata.weight != '0) begin
					div_req.start = 1'b1;
					div_req.num = rdata.sum;
					div_req.den = rdata.weight;
					state_d = ST_RD_AWAIT;
				end else begin
					state_d = ST_RD_CMUL;
				end
			end
			ST_RD_AWAIT: begin
				if (div_done) begin
					state_d = ST_RD_CMUL;
				end
			end
			ST_RD_CMUL: state_d = ST_RD_CGO;
			ST_RD_CGO: begin
				div_req.start = 1'b1;
				div_req.num = DIV_NUM_W'({mprod_q, 7'b0});
				div_req.den = DIV_DEN_W'(cols_eff);
				state_d = ST_RD_CWAIT;
			end
			ST_RD_CWAIT: begin
				if (div_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			from_q <= '0;
			to_q <= '0;
			cols_q <= CNT_W'(256);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FROM: from_q <= cfg_data;
				REG_TO:   to_q <= cfg_data;
				REG_COLS: cols_q <= cfg_data[CNT_W-1:0];
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (state_q == ST_IDLE && s_tvalid && cmd_in == CMD_CLEAR) begin
			valid_q <= '0;
		end else if (mem_we) begin
			valid_q[idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				t_q <= s_tdata[31:0];
				dur_q <= s_tdata[55:32];
				val_q <= s_tdata[79:56];
				lo_q <= s_tdata[103:80];
				hi_q <= s_tdata[127:104];
				col_q <= s_tdata[135:128];
				res_acc_q <= 1'b0;
				res_has_q <= 1'b0;
				res_low_q <= '0;
				res_high_q <= '0;
				res_avg_q <= '0;
				res_ctr_q <= '0;
			end
			ST_ADD_MUL: begin
				mprod_q <= (t_q - from_q) * cols_eff;
				wprod_q <= val_q * w;
			end
			ST_ADD_DWAIT: begin
				if (quot >= DIV_NUM_W'(cols_eff)) begin
					idx_q <= COL_W'(cols_eff - 1'b1);
				end else begin
					idx_q <= quot[COL_W-1:0];
				end
			end
			ST_ADD_WR: res_acc_q <= 1'b1;
			ST_RD_DAT: begin
				if (valid_q[col_q]) begin
					res_has_q <= 1'b1;
					res_low_q <= rdata.low;
					res_high_q <= rdata.high;
				end
			end
			ST_RD_AWAIT: begin
				res_avg_q <= (quot > DIV_NUM_W'({VAL_W{1'b1}})) ? '1 : quot[VAL_W-1:0];
			end
			ST_RD_CMUL: mprod_q <= span * {col_q, 1'b1};
			ST_RD_CWAIT: res_ctr_q <= {from_q, 8'b0} + quot[CTR_W-1:0];
			ST_FIN: begin
				if (out_load) begin
					m_tdata_q <= {6'b0, res_ctr_q, res_avg_q, res_high_q, res_low_q,
						res_has_q, res_acc_q};
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule

### sim/time_binned_min_max_average_tb.sv
`timescale 1ns / 100ps

module time_binned_min_max_average_tb;
	import tbmma_pkg::*;

	typedef struct {
		cmd_t             cmd;
		logic [31:0]      stamp;
		logic [23:0]      dur;
		logic [23:0]      val;
		logic [23:0]      lo;
		logic [23:0]      hi;
		logic [7:0]       col;
	} sample_t;

	typedef struct {
		logic        accepted;
		logic        has;
		logic [23:0] lo;
		logic [23:0] hi;
		logic [23:0] avg;
		logic [39:0] center;
	} column_rpt_t;

	class column_scoreboard;
		logic [31:0] win_from;
		logic [31:0] win_to;
		logic [8:0]  col_cnt;
		bit          occupied[MAX_COLUMNS];
		bit          ever_written[MAX_COLUMNS];
		logic [23:0] col_lo[MAX_COLUMNS];
		logic [23:0] col_hi[MAX_COLUMNS];
		logic [63:0] col_sum[MAX_COLUMNS];
		logic [63:0] col_wgt[MAX_COLUMNS];
		column_rpt_t pending_rpts[$];
		int          errors;

		function new();
			win_from = 32'd0;
			win_to = 32'd0;
			col_cnt = 9'd256;
			errors = 0;
			foreach (occupied[i]) begin
				occupied[i] = 0;
				ever_written[i] = 0;
			end
		endfunction

		function int active_cols();
			return (col_cnt > MAX_COLUMNS) ? MAX_COLUMNS : int'(col_cnt);
		endfunction

		function bit window_open();
			return active_cols() > 0 && win_to > win_from;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] data);
			case (idx)
				REG_FROM: win_from = data;
				REG_TO:   win_to = data;
				REG_COLS: col_cnt = data[8:0];
				default: ;
			endcase
		endfunction

		function void note_sample(sample_t s);
			column_rpt_t r;
			logic [63:0] span, idx, w, prod, cols;
			r = '{default: 0};
			cols = 64'(active_cols());
			span = {32'd0, win_to} - {32'd0, win_from};
			case (s.cmd)
				CMD_ADD: begin
					if (window_open() && s.stamp >= win_from) begin
						idx = ({32'd0, s.stamp - win_from} * cols) / span;
						if (idx >= cols)
							idx = cols - 64'd1;
						w = (s.dur != 0) ? {40'd0, s.dur} : 64'd256;
						if (!occupied[idx]) begin
							occupied[idx] = 1;
							ever_written[idx] = 1;
							col_lo[idx] = s.lo;
							col_hi[idx] = s.hi;
							col_sum[idx] = 64'd0;
							col_wgt[idx] = 64'd0;
						end else begin
							if (s.lo < col_lo[idx])
								col_lo[idx] = s.lo;
							if (s.hi > col_hi[idx])
								col_hi[idx] = s.hi;
						end
						prod = {40'd0, s.val} * w;
						if (col_sum[idx] > ~64'd0 - prod)
							col_sum[idx] = ~64'd0;
						else
							col_sum[idx] += prod;
						col_wgt[idx] += w;
						if (col_wgt[idx] > 64'hFFFF_FFFF_FFFF)
							col_wgt[idx] = 64'hFFFF_FFFF_FFFF;
						r.accepted = 1;
					end
				end
				CMD_READ: begin
					if (window_open() && {56'd0, s.col} < cols) begin
						if (occupied[s.col]) begin
							r.has = 1;
							r.lo = col_lo[s.col];
							r.hi = col_hi[s.col];
							if (col_wgt[s.col] != 0) begin
								prod = col_sum[s.col] / col_wgt[s.col];
								r.avg = (prod > 64'hFF_FFFF) ? 24'hFF_FFFF : prod[23:0];
							end
						end
						prod = ({32'd0, win_from} << 8)
							+ (span * (64'd2 * {56'd0, s.col} + 64'd1) * 64'd128) / cols;
						r.center = prod[39:0];
					end
				end
				CMD_CLEAR: begin
					foreach (occupied[i])
						occupied[i] = 0;
				end
				default: ;
			endcase
			pending_rpts.push_back(r);
		endfunction

		function void check_rpt(column_rpt_t got);
			column_rpt_t exp_r;
			if (pending_rpts.size() == 0) begin
				$error("result transaction with nothing expected");
				errors++;
				return;
			end
			exp_r = pending_rpts.pop_front();
			if (got.accepted !== exp_r.accepted) begin
				$error("accepted: expected %0h, got %0h", exp_r.accepted, got.accepted);
				errors++;
			end
			if (got.has !== exp_r.has) begin
				$error("column_has: expected %0h, got %0h", exp_r.has, got.has);
				errors++;
			end
			if (got.lo !== exp_r.lo) begin
				$error("column_low: expected %0h, got %0h", exp_r.lo, got.lo);
				errors++;
			end
			if (got.hi !== exp_r.hi) begin
				$error("column_high: expected %0h, got %0h", exp_r.hi, got.hi);
				errors++;
			end
			if (got.avg !== exp_r.avg) begin
				$error("column_avg: expected %0h, got %0h", exp_r.avg, got.avg);
				errors++;
			end
			if (got.center !== exp_r.center) begin
				$error("center_time_q8: expected %0h, got %0h", exp_r.center, got.center);
				errors++;
			end
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [135:0]  s_tdata;
	logic [1:0]    s_tuser;
	logic          m_tvalid;
	logic          m_tready;
	logic [119:0]  m_tdata;
	logic          cfg_we;
	logic [1:0]    cfg_index;
	logic [31:0]   cfg_data;

	column_scoreboard sb;
	bit               quiet;
	int unsigned      cycle_cnt = 0;

	time_binned_min_max_average u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > 3000000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		column_rpt_t got;
		if (m_tvalid && m_tready) begin
			got.accepted = m_tdata[0];
			got.has = m_tdata[1];
			got.lo = m_tdata[25:2];
			got.hi = m_tdata[49:26];
			got.avg = m_tdata[73:50];
			got.center = m_tdata[113:74];
			sb.check_rpt(got);
		end
	end

	initial begin
		int n;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 13);
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic send(sample_t s);
		int n;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 13);
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= s.cmd;
		s_tdata <= {s.col, s.hi, s.lo, s.val, s.dur, s.stamp};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_sample(s);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] data);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_rpts.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, data);
	endtask

	task automatic set_window(logic [31:0] f, logic [31:0] t, logic [8:0] c);
		write_reg(REG_FROM, f);
		write_reg(REG_TO, t);
		write_reg(REG_COLS, {23'd0, c});
	endtask

	function automatic sample_t make(cmd_t c, logic [31:0] t, logic [7:0] col);
		sample_t s;
		s.cmd = c;
		s.stamp = t;
		s.dur = 24'($urandom());
		s.val = 24'($urandom());
		s.lo = 24'($urandom());
		s.hi = 24'($urandom());
		s.col = col;
		return s;
	endfunction

	// In an open window, reads of in-range columns that were never written are steered to written ones where any exist.
	function automatic logic [7:0] safe_col(logic [7:0] c);
		int cols;
		cols = sb.active_cols();
		if (!sb.window_open() || c >= cols || sb.ever_written[c])
			return c;
		for (int i = 0; i < 256; i++)
			if (sb.ever_written[(c + i) % 256] && (c + i) % 256 < cols)
				return 8'((c + i) % 256);
		return (cols < 256) ? cols[7:0] : c;
	endfunction

	task automatic random_items(int cnt);
		sample_t s;
		logic [63:0] span, t;
		int r;
		span = {32'd0, sb.win_to} - {32'd0, sb.win_from};
		for (int i = 0; i < cnt; i++) begin
			r = $urandom_range(0, 99);
			t = {32'd0, sb.win_from} + (({$urandom(), $urandom()}) % (span + span / 8 + 1));
			if (t > 64'hFFFF_FFFF)
				t = 64'hFFFF_FFFF;
			if (r < 8)
				t = {32'd0, $urandom()};
			if (r < 60) begin
				s = make(CMD_ADD, t[31:0], 8'($urandom()));
				if (r < 20)
					s.dur = 24'($urandom_range(0, 3));
			end else if (r < 94) begin
				s = make(CMD_READ, $urandom(), 8'd0);
				s.col = safe_col(8'($urandom()));
			end else if (r < 97) begin
				s = make(CMD_CLEAR, $urandom(), 8'($urandom()));
			end else begin
				s = make(CMD_NOP, $urandom(), 8'($urandom()));
			end
			send(s);
		end
	endtask

	initial begin
		sample_t s;
		sb = new();
		quiet = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_NOP;
		cfg_we = 1'b0;
		cfg_index = REG_FROM;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Window closed after reset: adds drop, reads return zero.
		send(make(CMD_ADD, 32'd5, 8'd0));
		send(make(CMD_READ, 32'd0, 8'd0));

		set_window(32'd1000, 32'd2000, 9'd10);
		send(make(CMD_ADD, 32'd999, 8'd0));
		s = make(CMD_ADD, 32'd1000, 8'd0);
		s.dur = 24'd0;
		s.val = 24'hFF_FFFF;
		s.lo = 24'hFF_FFFF;
		s.hi = 24'd0;
		send(s);
		s = make(CMD_ADD, 32'd1050, 8'd0);
		s.dur = 24'hFF_FFFF;
		s.val = 24'd0;
		s.lo = 24'd0;
		s.hi = 24'hFF_FFFF;
		send(s);
		send(make(CMD_ADD, 32'd1999, 8'd0));
		send(make(CMD_ADD, 32'hFFFF_FFFF, 8'd0));
		send(make(CMD_ADD, 32'd2000, 8'd0));
		send(make(CMD_READ, 32'd0, 8'd0));
		send(make(CMD_READ, 32'd0, 8'd9));
		send(make(CMD_READ, 32'd0, 8'd10));
		send(make(CMD_READ, 32'd0, 8'd255));
		send(make(CMD_NOP, 32'hFFFF_FFFF, 8'hFF));
		send(make(CMD_CLEAR, 32'd0, 8'd0));
		send(make(CMD_READ, 32'd0, 8'd0));
		send(make(CMD_READ, 32'd0, 8'd9));
		random_items(60);

		set_window(32'd0, 32'hFFFF_FFFF, 9'd256);
		random_items(140);
		set_window(32'hFFFF_FFFE, 32'hFFFF_FFFF, 9'd1);
		random_items(30);
		set_window(32'd500, 32'd500, 9'd16);
		random_items(20);
		set_window(32'd0, 32'd300, 9'd0);
		random_items(20);
		set_window(32'd17, 32'd100017, 9'd511);
		random_items(120);
		set_window(32'd40000, 32'd40007, 9'd7);
		quiet = 1;
		random_items(80);

		s_tvalid <= 1'b0;
		while (sb.pending_rpts.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

### time_binned_min_max_average.f
src/tbmma_pkg.sv
src/tbmma_div.sv
src/tbmma_bin_ram.sv
src/time_binned_min_max_average.sv
sim/time_binned_min_max_average_tb.sv
